>>> rtl/rkc_pkg.sv
// Shared types and constants for the 3x3 RGB convolution block.
// Used by rkc_lane, rkc_merge and rgb_kernel_convolution; no dependencies.
`default_nettype none

package rkc_pkg;

    // Window and kernel geometry
    localparam int KERNEL_SIZE = 3;
    localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
    localparam int CH_N        = 3;

    // Pixel and coefficient formats
    localparam int PIX_W   = 8;
    localparam int RGB_W   = CH_N * PIX_W;
    localparam int SLOT_W  = 16;
    localparam int COEF_W  = 16;
    localparam int FRAC_W  = 8;
    localparam int ROW_W   = KERNEL_SIZE * SLOT_W;

    // Datapath widths: 8-bit unsigned pixel times signed coefficient,
    // then one row sum of three products, then the sum of three rows
    localparam int PROD_W  = PIX_W + COEF_W;
    localparam int GRP_W   = PROD_W + 2;
    localparam int SUM_W   = PROD_W + 4;
    localparam int WHOLE_W = SUM_W - FRAC_W;

    localparam logic [PIX_W-1:0] PIX_MAX = PIX_W'(255);
    localparam logic [PIX_W-1:0] PIX_MIN = PIX_W'(0);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = ROW_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_TOP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_MID = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BOT = CFG_IDX_W'(2);

    // Reset kernel: identity, 1.0 in the center slot of the middle row
    localparam logic [ROW_W-1:0] ROW_TOP_RST = '0;
    localparam logic [ROW_W-1:0] ROW_MID_RST = ROW_W'(1) << (SLOT_W + FRAC_W);
    localparam logic [ROW_W-1:0] ROW_BOT_RST = '0;

    // Input item: one 3x3 window of packed RGB pixels
    typedef struct packed {
        logic [RGB_W-1:0] win_top_left;
        logic [RGB_W-1:0] win_top_mid;
        logic [RGB_W-1:0] win_top_right;
        logic [RGB_W-1:0] win_mid_left;
        logic [RGB_W-1:0] win_center;
        logic [RGB_W-1:0] win_mid_right;
        logic [RGB_W-1:0] win_bot_left;
        logic [RGB_W-1:0] win_bot_mid;
        logic [RGB_W-1:0] win_bot_right;
    } t_window;

    // Result item: one filtered pixel
    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
    } t_result;

    // Per-lane tap vectors and the lane sums handed to the merge stage
    typedef logic [TAPS-1:0][PIX_W-1:0]  t_tap_pix;
    typedef logic [TAPS-1:0][COEF_W-1:0] t_tap_coef;
    typedef logic [CH_N-1:0][SUM_W-1:0]  t_ch_sum;

endpackage

`default_nettype wire

>>> rtl/rkc_lane.sv
// One color lane: nine pixel-by-coefficient products, row sums, window sum.
// Three register stages; depends on rkc_pkg.
`default_nettype none

module rkc_lane (
    input  wire logic                       i_clk,
    input  wire rkc_pkg::t_tap_pix          i_pix,
    input  wire rkc_pkg::t_tap_coef         i_coef,
    output logic [rkc_pkg::SUM_W-1:0]       o_sum
);

    logic [rkc_pkg::TAPS-1:0][rkc_pkg::PROD_W:0]          n_full;
    logic [rkc_pkg::TAPS-1:0][rkc_pkg::PROD_W-1:0]        n_prod;
    logic [rkc_pkg::TAPS-1:0][rkc_pkg::PROD_W-1:0]        r_prod;
    logic [rkc_pkg::KERNEL_SIZE-1:0][rkc_pkg::GRP_W-1:0]  n_grp;
    logic [rkc_pkg::KERNEL_SIZE-1:0][rkc_pkg::GRP_W-1:0]  r_grp;
    logic [rkc_pkg::SUM_W-1:0]                            n_sum;
    logic [rkc_pkg::SUM_W-1:0]                            r_sum;

    // Multiply each unsigned pixel by its signed coefficient
    always_comb begin
        for (int t = 0; t < rkc_pkg::TAPS; t++) begin
            n_full[t] = $signed({1'b0, i_pix[t]}) * $signed(i_coef[t]);
            n_prod[t] = n_full[t][rkc_pkg::PROD_W-1:0];
        end
    end

    // Sum the three products of each kernel row
    always_comb begin
        for (int g = 0; g < rkc_pkg::KERNEL_SIZE; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < rkc_pkg::KERNEL_SIZE; k++) begin
                n_grp[g] = n_grp[g] + rkc_pkg::GRP_W'(
                    $signed(r_prod[g * rkc_pkg::KERNEL_SIZE + k]));
            end
        end
    end

    // Sum the row sums
    always_comb begin
        n_sum = '0;
        for (int g = 0; g < rkc_pkg::KERNEL_SIZE; g++) begin
            n_sum = n_sum + rkc_pkg::SUM_W'($signed(r_grp[g]));
        end
    end

    // Advance the payload pipeline every cycle
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_grp  <= n_grp;
        r_sum  <= n_sum;
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

>>> rtl/rkc_merge.sv
// Merge stage: drop the fraction of each lane sum, clamp to 0..255, pack.
// Registers the result and its strobe; depends on rkc_pkg.
`default_nettype none

module rkc_merge (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire rkc_pkg::t_ch_sum  i_sum,
    output logic                   o_done,
    output rkc_pkg::t_result       o_result
);

    logic              r_done;
    rkc_pkg::t_result  r_result;
    rkc_pkg::t_result  n_result;

    // Floor and saturate one channel sum
    function automatic logic [rkc_pkg::PIX_W-1:0] clamp_ch(
        input logic [rkc_pkg::SUM_W-1:0] sum
    );
        logic [rkc_pkg::WHOLE_W-1:0] whole;
        whole = sum[rkc_pkg::SUM_W-1:rkc_pkg::FRAC_W];
        if (sum[rkc_pkg::SUM_W-1]) begin
            return rkc_pkg::PIX_MIN;
        end else if (whole > rkc_pkg::WHOLE_W'(rkc_pkg::PIX_MAX)) begin
            return rkc_pkg::PIX_MAX;
        end else begin
            return whole[rkc_pkg::PIX_W-1:0];
        end
    endfunction

    // Channel 0 is red, 1 green, 2 blue
    always_comb begin
        n_result.out_red   = clamp_ch(i_sum[0]);
        n_result.out_green = clamp_ch(i_sum[1]);
        n_result.out_blue  = clamp_ch(i_sum[2]);
    end

    // Hold the payload; the strobe is control and resets
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

>>> rtl/rgb_kernel_convolution.sv
// 3x3 RGB convolution, top level: three color lanes and a merge stage.
// A transferred window passes the product, row-sum and window-sum registers of each
// lane and the merge register before o_done rises. Throughput: one window per clock; busy
// stays low, since the multiplier and adder-tree stages are fully pipelined.
// Reset (synchronous, active low) restores the identity kernel and clears the
// strobe pipeline. The receiver cannot stall; results leave on o_done.
`default_nettype none

module rgb_kernel_convolution (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire rkc_pkg::t_window                   i_window,
    output logic                                    o_done,
    output rkc_pkg::t_result                        o_result,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [rkc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [rkc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [rkc_pkg::ROW_W-1:0]                             r_row_top;
    logic [rkc_pkg::ROW_W-1:0]                             r_row_mid;
    logic [rkc_pkg::ROW_W-1:0]                             r_row_bot;
    logic [rkc_pkg::KERNEL_SIZE-1:0][rkc_pkg::ROW_W-1:0]   w_rows;
    logic [rkc_pkg::TAPS-1:0][rkc_pkg::RGB_W-1:0]          w_taps;
    rkc_pkg::t_tap_pix [rkc_pkg::CH_N-1:0]                 w_pix;
    rkc_pkg::t_tap_coef                                    w_coef;
    rkc_pkg::t_ch_sum                                      w_sum;
    logic [2:0]                                            r_vld;
    logic                                                  w_accept;

    // Never stall: a new window every cycle
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    // Kernel registers; an index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_top <= rkc_pkg::ROW_TOP_RST;
            r_row_mid <= rkc_pkg::ROW_MID_RST;
            r_row_bot <= rkc_pkg::ROW_BOT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rkc_pkg::CFG_ROW_TOP: r_row_top <= i_cfg_data;
                rkc_pkg::CFG_ROW_MID: r_row_mid <= i_cfg_data;
                rkc_pkg::CFG_ROW_BOT: r_row_bot <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Flatten the window in row-major order
    always_comb begin
        w_taps[0] = i_window.win_top_left;
        w_taps[1] = i_window.win_top_mid;
        w_taps[2] = i_window.win_top_right;
        w_taps[3] = i_window.win_mid_left;
        w_taps[4] = i_window.win_center;
        w_taps[5] = i_window.win_mid_right;
        w_taps[6] = i_window.win_bot_left;
        w_taps[7] = i_window.win_bot_mid;
        w_taps[8] = i_window.win_bot_right;
        w_rows[0] = r_row_top;
        w_rows[1] = r_row_mid;
        w_rows[2] = r_row_bot;
    end

    // Split pixels into channels and rows into coefficient slots
    always_comb begin
        for (int t = 0; t < rkc_pkg::TAPS; t++) begin
            for (int ch = 0; ch < rkc_pkg::CH_N; ch++) begin
                w_pix[ch][t] = w_taps[t][rkc_pkg::RGB_W - 1 - rkc_pkg::PIX_W * ch
                                         -: rkc_pkg::PIX_W];
            end
            w_coef[t] = w_rows[t / rkc_pkg::KERNEL_SIZE]
                              [rkc_pkg::SLOT_W * (t % rkc_pkg::KERNEL_SIZE)
                               +: rkc_pkg::COEF_W];
        end
    end

    // One lane per color channel
    for (genvar ch = 0; ch < rkc_pkg::CH_N; ch++) begin : g_lane
        rkc_lane u_lane (
            .i_clk  (i_clk),
            .i_pix  (w_pix[ch]),
            .i_coef (w_coef),
            .o_sum  (w_sum[ch])
        );
    end

    // Track transfers alongside the lane pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], w_accept};
        end
    end

    rkc_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_vld[2]),
        .i_sum    (w_sum),
        .o_done   (o_done),
        .o_result (o_result)
    );

`ifndef NO_ASSERTIONS
    // Every transfer yields a result
    a_accept_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##4 o_done)
        else $error("transfer did not produce a result");

    // No result without a matching transfer in the valid pipeline
    a_done_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_vld[2]))
        else $error("result strobe without a matching transfer");

    // A negative red sum clamps to zero
    a_red_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(w_sum[0][rkc_pkg::SUM_W-1])) |-> (o_result.out_red == '0))
        else $error("negative red sum not clamped to zero");
`endif

endmodule

`default_nettype wire
